// File: rtl/core/assert_macros.svh
// Assertion macros shared by the linked-list engine RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("%m: assertion failed");
`define ASSERT_ALWAYS(label, clock, prop) \
  label: assert property (@(posedge clock) prop) \
    else $error("%m: assertion failed");
`else
`define ASSERT_RST(label, clock, reset, prop)
`define ASSERT_ALWAYS(label, clock, prop)
`endif

`endif

// File: rtl/core/slle_pkg.sv
// Shared types and constants of the static linked-list engine.
// Used by the controller, the datapath and the top level; no dependencies.
package slle_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 6;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 6;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_HEAD = 2'd1,
    RD_LINK = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_ZERO  = 2'd0,
    WA_K     = 2'd1,
    WA_FRESH = 2'd2
  } wr_addr_sel_t;

  typedef enum logic {
    WD_LINK  = 1'b0,
    WD_FRESH = 1'b1
  } wr_data_sel_t;

  typedef enum logic [1:0] {
    OUT_OK   = 2'd0,
    OUT_ERR  = 2'd1,
    OUT_ELEM = 2'd2
  } out_kind_t;

  typedef struct packed {
    logic         latch_in;
    logic         rd_en;
    rd_sel_t      rd_sel;
    logic         wr_en;
    wr_addr_sel_t wr_addr_sel;
    wr_data_sel_t wr_data_sel;
    logic         es_wr;
    logic         ld_fresh;
    logic         k_ld_head;
    logic         k_ld_link;
    logic         step_init;
    logic         step_inc;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         cnt_clr;
    logic         out_load;
    out_kind_t    out_kind;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ins_ok;
    logic del_ok;
    logic cnt_zero;
    logic link_zero;
    logic pos_one;
    logic walk_last;
    logic trav_fin;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/static_linked_list_engine_unit.sv
// Static linked-list engine: insert, delete, traverse and clear, one command at a
// time. A traverse emits one element per cycle while results are taken; the next
// command is accepted only once the previous one, rejected or not, is finished.
// Insert and delete walk down the link chain, one link-memory read a cycle.
// Reset (synchronous, active high) empties the list at once; no clearing pass.
// Depends on slle_pkg, slle_ctrl, slle_dp, slle_ram and assert_macros.svh.
`include "assert_macros.svh"

module static_linked_list_engine_unit #(
  parameter int LIST_SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [slle_pkg::OP_W-1:0]    op,
  input  logic [slle_pkg::POS_W-1:0]   position,
  input  logic [slle_pkg::DATA_W-1:0]  data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic [slle_pkg::CNT_W-1:0]   count,
  output logic [slle_pkg::DATA_W-1:0]  element,
  output logic                         element_valid,
  output logic                         last
);
  import slle_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slle_dp #(.LIST_SLOTS(LIST_SLOTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .position      (position),
    .data          (data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .count         (count),
    .element       (element),
    .element_valid (element_valid),
    .last          (last)
  );

  `ASSERT_RST(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `ASSERT_RST(a_count_bound, clk, rst, out_valid |-> (count <= CNT_W'(LIST_SLOTS - 2)))
  `ASSERT_RST(a_err_no_elem, clk, rst, (out_valid && status) |-> (!element_valid && last))
  `ASSERT_RST(a_empty_is_zero, clk, rst, (out_valid && !element_valid) |-> (element == '0 && last))

endmodule

// File: rtl/core/slle_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module slle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/slle_ctrl.sv
// Controller of the linked-list engine: sequences each operation as a
// series of link-memory reads and writes. Depends on slle_pkg.
module slle_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  slle_pkg::stat_t stat,
  output slle_pkg::cmd_t  cmd
);
  import slle_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_INS_POP    = 4'd2;
  localparam logic [3:0] S_WALK       = 4'd3;
  localparam logic [3:0] S_INS_LINK   = 4'd4;
  localparam logic [3:0] S_INS_HOOK   = 4'd5;
  localparam logic [3:0] S_DEL_VICT   = 4'd6;
  localparam logic [3:0] S_DEL_UNLINK = 4'd7;
  localparam logic [3:0] S_DEL_FREE   = 4'd8;
  localparam logic [3:0] S_DEL_PUSH   = 4'd9;
  localparam logic [3:0] S_TRAV_HEAD  = 4'd10;
  localparam logic [3:0] S_TRAV_EMIT  = 4'd11;
  localparam logic [3:0] S_REPLY      = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  out_kind_t  reply;
  out_kind_t  reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reply <= OUT_OK;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    reply_next = reply;
    case (state)
      S_IDLE: begin
        // The free-list head is fetched up front; insert needs it next cycle.
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_ZERO;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.ins_ok) begin
              cmd.ld_fresh = 1'b1;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_LINK;
              state_next   = S_INS_POP;
            end else begin
              reply_next = OUT_ERR;
              state_next = S_REPLY;
            end
          end
          OP_DELETE: begin
            if (stat.del_ok) begin
              cmd.rd_en     = 1'b1;
              cmd.rd_sel    = RD_HEAD;
              cmd.k_ld_head = 1'b1;
              cmd.step_init = 1'b1;
              state_next    = stat.pos_one ? S_DEL_VICT : S_WALK;
            end else begin
              reply_next = OUT_ERR;
              state_next = S_REPLY;
            end
          end
          OP_TRAVERSE: begin
            if (stat.cnt_zero) begin
              reply_next = OUT_OK;
              state_next = S_REPLY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_next = S_TRAV_HEAD;
            end
          end
          default: begin
            cmd.cnt_clr = 1'b1;
            reply_next  = OUT_OK;
            state_next  = S_REPLY;
          end
        endcase
      end
      S_INS_POP: begin
        // Unlink the fresh slot from the free list and start the walk.
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_ZERO;
        cmd.wr_data_sel = WD_LINK;
        cmd.es_wr       = 1'b1;
        cmd.rd_en       = 1'b1;
        cmd.rd_sel      = RD_HEAD;
        cmd.k_ld_head   = 1'b1;
        cmd.step_init   = 1'b1;
        state_next      = stat.pos_one ? S_INS_LINK : S_WALK;
      end
      S_WALK: begin
        cmd.k_ld_link = 1'b1;
        cmd.step_inc  = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_LINK;
        if (stat.walk_last) begin
          state_next = (stat.op == OP_INSERT) ? S_INS_LINK : S_DEL_VICT;
        end
      end
      S_INS_LINK: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_FRESH;
        cmd.wr_data_sel = WD_LINK;
        state_next      = S_INS_HOOK;
      end
      S_INS_HOOK: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_K;
        cmd.wr_data_sel = WD_FRESH;
        cmd.cnt_inc     = 1'b1;
        reply_next      = OUT_OK;
        state_next      = S_REPLY;
      end
      S_DEL_VICT: begin
        cmd.ld_fresh = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_LINK;
        state_next   = S_DEL_UNLINK;
      end
      S_DEL_UNLINK: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_K;
        cmd.wr_data_sel = WD_LINK;
        cmd.rd_en       = 1'b1;
        cmd.rd_sel      = RD_ZERO;
        state_next      = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_FRESH;
        cmd.wr_data_sel = WD_LINK;
        state_next      = S_DEL_PUSH;
      end
      S_DEL_PUSH: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_ZERO;
        cmd.wr_data_sel = WD_FRESH;
        cmd.cnt_dec     = 1'b1;
        reply_next      = OUT_OK;
        state_next      = S_REPLY;
      end
      S_TRAV_HEAD: begin
        if (stat.link_zero) begin
          reply_next = OUT_OK;
          state_next = S_REPLY;
        end else begin
          cmd.step_init = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_LINK;
          state_next    = S_TRAV_EMIT;
        end
      end
      S_TRAV_EMIT: begin
        // One element per beat; the next node is fetched as this one leaves.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_ELEM;
          if (stat.trav_fin) begin
            state_next = S_IDLE;
          end else begin
            cmd.step_inc = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_LINK;
          end
        end
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = reply;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/slle_dp.sv
// Datapath of the linked-list engine: link and element memories, walk
// registers, element count and the output register. Depends on slle_pkg, slle_ram.
module slle_dp #(
  parameter int LIST_SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  slle_pkg::cmd_t               cmd,
  output slle_pkg::stat_t              stat,
  input  logic [slle_pkg::OP_W-1:0]    op,
  input  logic [slle_pkg::POS_W-1:0]   position,
  input  logic [slle_pkg::DATA_W-1:0]  data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic [slle_pkg::CNT_W-1:0]   count,
  output logic [slle_pkg::DATA_W-1:0]  element,
  output logic                         element_valid,
  output logic                         last
);
  import slle_pkg::*;

  localparam int IW  = $clog2(LIST_SLOTS);
  localparam int CW1 = CNT_W + 1;
  localparam logic [IW-1:0]    HEAD = IW'(LIST_SLOTS - 1);
  localparam logic [CNT_W-1:0] CAP  = CNT_W'(LIST_SLOTS - 2);

  // Link value of a slot that has not been written since reset or clear.
  function automatic logic [IW-1:0] reset_link(input logic [IW-1:0] a);
    logic [IW-1:0] r;
    r = '0;
    if (int'(a) < LIST_SLOTS - 2) begin
      r = a + IW'(1);
    end
    return r;
  endfunction

  op_t                op_q;
  logic [POS_W-1:0]   pos_q;
  logic [DATA_W-1:0]  data_q;
  logic [CNT_W-1:0]   cnt;
  logic [IW-1:0]      k;
  logic [IW-1:0]      fresh;
  logic [CNT_W-1:0]   step;
  logic [LIST_SLOTS-1:0] vld;
  logic               rd_vld_q;
  logic [IW-1:0]      rd_addr_q;

  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      wr_data;
  logic [IW-1:0]      link_raw;
  logic [IW-1:0]      link;
  logic [DATA_W-1:0]  es_rd;

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_HEAD: rd_addr = HEAD;
      RD_LINK: rd_addr = link;
      default: rd_addr = '0;
    endcase
    case (cmd.wr_addr_sel)
      WA_ZERO:  wr_addr = '0;
      WA_K:     wr_addr = k;
      WA_FRESH: wr_addr = fresh;
      default:  wr_addr = '0;
    endcase
    wr_data = (cmd.wr_data_sel == WD_FRESH) ? fresh : link;
  end

  slle_ram #(.WIDTH(IW), .DEPTH(LIST_SLOTS)) u_link_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (link_raw)
  );

  slle_ram #(.WIDTH(DATA_W), .DEPTH(LIST_SLOTS)) u_elem_ram (
    .clk     (clk),
    .wr_en   (cmd.es_wr),
    .wr_addr (fresh),
    .wr_data (data_q),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (es_rd)
  );

  assign link = rd_vld_q ? link_raw : reset_link(rd_addr_q);

  // Per-slot written flags stand in for the initial free chain, so reset
  // and clear take effect at once without sweeping the link memory.
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      vld <= '0;
    end else if (cmd.wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q   <= op_t'(op);
      pos_q  <= position;
      data_q <= data;
    end
    if (cmd.rd_en) begin
      rd_vld_q  <= vld[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (cmd.ld_fresh) begin
      fresh <= link;
    end
    if (cmd.k_ld_head) begin
      k <= HEAD;
    end else if (cmd.k_ld_link) begin
      k <= link;
    end
    if (cmd.step_init) begin
      step <= CNT_W'(1);
    end else if (cmd.step_inc) begin
      step <= step + CNT_W'(1);
    end
    if (cmd.out_load) begin
      count <= cnt;
      case (cmd.out_kind)
        OUT_ELEM: begin
          status        <= 1'b0;
          element       <= es_rd;
          element_valid <= 1'b1;
          last          <= stat.trav_fin;
        end
        OUT_ERR: begin
          status        <= 1'b1;
          element       <= '0;
          element_valid <= 1'b0;
          last          <= 1'b1;
        end
        default: begin
          status        <= 1'b0;
          element       <= '0;
          element_valid <= 1'b0;
          last          <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    stat.op        = op_q;
    stat.link_zero = (link == '0);
    stat.cnt_zero  = (cnt == '0);
    stat.pos_one   = (pos_q == POS_W'(1));
    stat.ins_ok    = (pos_q != '0) && (CW1'(pos_q) <= CW1'(cnt) + CW1'(1)) &&
                     (cnt < CAP) && (link != '0);
    stat.del_ok    = (pos_q != '0) && (pos_q <= cnt);
    stat.walk_last = (CW1'(step) + CW1'(1) == CW1'(pos_q));
    stat.trav_fin  = (step == cnt) || (link == '0);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

// File: tb/tb_static_linked_list_engine_unit.sv
// Self-checking testbench for static_linked_list_engine_unit.
// Keeps its own copy of the link and data stores and checks every result beat.
// Depends on slle_pkg and the engine RTL only.
`timescale 1ns / 100ps

module tb_static_linked_list_engine_unit;
  import slle_pkg::*;

  localparam int SLOTS      = 64;
  localparam int HEAD       = SLOTS - 1;
  localparam int CAPACITY   = SLOTS - 2;
  localparam int HALF_CLK   = 6;
  localparam int LIMIT_CLKS = 1_000_000;
  localparam int DRAIN_CLKS = 80;

  typedef struct packed {
    logic       status;
    logic [5:0] count;
    logic [7:0] element;
    logic       element_valid;
    logic       last;
  } list_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] op = OP_INSERT;
  logic [5:0] position = '0;
  logic [7:0] data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       status;
  logic [5:0] count;
  logic [7:0] element;
  logic       element_valid;
  logic       last;

  // Shadow of the engine: links, stored bytes and list length.
  logic [5:0]  link_of [SLOTS];
  logic [7:0]  byte_of [SLOTS];
  int          list_len;
  list_reply_t list_replies[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int commands_sent = 0;
  int traversals = 0;
  int rejects = 0;
  int beats_checked = 0;
  int fault_count = 0;

  static_linked_list_engine_unit #(
    .LIST_SLOTS(SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .position(position),
    .data(data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .count(count),
    .element(element),
    .element_valid(element_valid),
    .last(last)
  );

  always begin
    clk = 1'b1;
    #HALF_CLK;
    clk = 1'b0;
    #HALF_CLK;
  end

  initial begin
    #(HALF_CLK * 2 * LIMIT_CLKS);
    $display("FAIL");
    $finish;
  end

  task automatic rebuild_free_chain();
    for (int s = 0; s < SLOTS; s++) begin
      link_of[s] = (s + 2 < SLOTS) ? 6'(s + 1) : 6'd0;
    end
    list_len = 0;
  endtask

  function automatic logic [5:0] slot_ahead_of(input int pos);
    logic [5:0] k;
    k = 6'(HEAD);
    for (int step = 1; step < pos; step++) begin
      k = link_of[k];
    end
    return k;
  endfunction

  task automatic push_reply(input logic err, input logic [7:0] elem, input logic ev,
                            input logic fin);
    list_reply_t r;
    r.status        = err;
    r.count         = 6'(list_len);
    r.element       = elem;
    r.element_valid = ev;
    r.last          = fin;
    list_replies.push_back(r);
  endtask

  // Applies one accepted command to the shadow and queues the beats it causes.
  task automatic apply_list_op(input op_t cmd, input int pos, input logic [7:0] value);
    logic [5:0] fresh;
    logic [5:0] k;
    logic [5:0] victim;
    logic [5:0] s;
    logic [5:0] nx;
    logic       fin;
    int         n;
    case (cmd)
      OP_INSERT: begin
        fresh = link_of[0];
        if (pos < 1 || pos > list_len + 1 || fresh == 0 || list_len >= CAPACITY) begin
          rejects++;
          push_reply(1'b1, 8'h00, 1'b0, 1'b1);
        end else begin
          link_of[0] = link_of[fresh];
          byte_of[fresh] = value;
          k = slot_ahead_of(pos);
          link_of[fresh] = link_of[k];
          link_of[k] = fresh;
          list_len++;
          push_reply(1'b0, 8'h00, 1'b0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          rejects++;
          push_reply(1'b1, 8'h00, 1'b0, 1'b1);
        end else begin
          k = slot_ahead_of(pos);
          victim = link_of[k];
          link_of[k] = link_of[victim];
          link_of[victim] = link_of[0];
          link_of[0] = victim;
          list_len--;
          push_reply(1'b0, 8'h00, 1'b0, 1'b1);
        end
      end
      OP_TRAVERSE: begin
        traversals++;
        n = 0;
        s = link_of[HEAD];
        while (list_len > 0 && s != 0 && n < list_len) begin
          nx = link_of[s];
          fin = (n + 1 == list_len) || (nx == 0);
          push_reply(1'b0, byte_of[s], 1'b1, fin);
          n++;
          if (fin) break;
          s = nx;
        end
        // An empty list still answers with one beat that carries no element.
        if (n == 0) push_reply(1'b0, 8'h00, 1'b0, 1'b1);
      end
      default: begin
        rebuild_free_chain();
        push_reply(1'b0, 8'h00, 1'b0, 1'b1);
      end
    endcase
  endtask

  // Presents one command after a random idle gap and models it once accepted.
  task automatic send_command(input op_t cmd, input int pos, input logic [7:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= cmd;
    position <= 6'(pos);
    data     <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    commands_sent++;
    apply_list_op(cmd, pos, value);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : reply_checker
    list_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (list_replies.size() == 0) begin
        $error("unexpected result beat: status %0d count %0d element %0d", status, count,
               element);
        fault_count++;
      end else begin
        want = list_replies.pop_front();
        beats_checked++;
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fault_count++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          fault_count++;
        end
        if (element !== want.element) begin
          $error("element: expected %0d, got %0d", want.element, element);
          fault_count++;
        end
        if (element_valid !== want.element_valid) begin
          $error("element_valid: expected %0d, got %0d", want.element_valid, element_valid);
          fault_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fault_count++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_command(OP_TRAVERSE, 0, 8'h00);
    send_command(OP_DELETE, 1, 8'h00);
    send_command(OP_INSERT, 0, 8'h11);
    send_command(OP_INSERT, 2, 8'h22);
  endtask

  task automatic test_head_tail_middle_edits();
    send_command(OP_INSERT, 1, 8'h00);
    send_command(OP_INSERT, 1, 8'hFF);
    send_command(OP_INSERT, 3, 8'h5A);
    send_command(OP_INSERT, 2, 8'hA5);
    send_command(OP_TRAVERSE, 0, 8'h00);
    send_command(OP_DELETE, 0, 8'h00);
    send_command(OP_DELETE, 5, 8'h00);
    send_command(OP_INSERT, 6, 8'h77);
    send_command(OP_INSERT, 63, 8'h77);
    send_command(OP_DELETE, 2, 8'h00);
    send_command(OP_DELETE, 3, 8'h00);
    send_command(OP_DELETE, 1, 8'h00);
    send_command(OP_TRAVERSE, 63, 8'hFF);
  endtask

  task automatic test_clear();
    send_command(OP_INSERT, 1, 8'h3C);
    send_command(OP_CLEAR, 0, 8'h00);
    send_command(OP_TRAVERSE, 0, 8'h00);
    send_command(OP_CLEAR, 63, 8'hFF);
  endtask

  // Fills every data slot, then pokes at the boundaries of a full list.
  task automatic test_full_list();
    send_command(OP_CLEAR, 0, 8'h00);
    while (list_len < CAPACITY) begin
      send_command(OP_INSERT, $urandom_range(list_len + 1, 1), 8'($urandom_range(255)));
    end
    send_command(OP_INSERT, 1, 8'hC3);
    send_command(OP_INSERT, 63, 8'hC3);
    send_command(OP_TRAVERSE, 0, 8'h00);
    send_command(OP_DELETE, 63, 8'h00);
    send_command(OP_DELETE, 62, 8'h00);
    send_command(OP_INSERT, 62, 8'h96);
    send_command(OP_DELETE, 1, 8'h00);
    send_command(OP_TRAVERSE, 0, 8'h00);
  endtask

  // Mostly legal edits that sweep the length between random goals, with
  // some traversals, a few clears and some malformed commands mixed in.
  task automatic test_random_edits(input int num_cmds);
    int  r;
    int  pos;
    int  goal;
    bit  growing;
    bit  do_insert;
    growing = 1'b1;
    goal = ($urandom_range(1) == 1) ? CAPACITY : $urandom_range(CAPACITY - 1, 4);
    for (int i = 0; i < num_cmds; i++) begin
      if (growing && list_len >= goal) begin
        growing = 1'b0;
        goal = ($urandom_range(2) == 0) ? 0 : $urandom_range(list_len - 1, 0);
      end else if (!growing && list_len <= goal) begin
        growing = 1'b1;
        goal = ($urandom_range(1) == 1) ? CAPACITY : $urandom_range(CAPACITY, list_len + 1);
      end
      r = $urandom_range(99);
      if (r < 8) begin
        send_command(op_t'(2'($urandom_range(3))), $urandom_range(63),
                     8'($urandom_range(255)));
      end else if (r < 17) begin
        send_command(OP_TRAVERSE, $urandom_range(63), 8'($urandom_range(255)));
      end else if (r < 19) begin
        send_command(OP_CLEAR, $urandom_range(63), 8'($urandom_range(255)));
      end else begin
        do_insert = growing ? ($urandom_range(99) < 75) : ($urandom_range(99) < 25);
        if (list_len == 0) do_insert = 1'b1;
        if (do_insert) begin
          r = $urandom_range(3);
          pos = (r == 0) ? 1 : (r == 1) ? list_len + 1 : $urandom_range(list_len + 1, 1);
          send_command(OP_INSERT, pos, 8'($urandom_range(255)));
        end else begin
          r = $urandom_range(3);
          pos = (r == 0) ? 1 : (r == 1) ? list_len : $urandom_range(list_len, 1);
          send_command(OP_DELETE, pos, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    rebuild_free_chain();
    for (int s = 0; s < SLOTS; s++) byte_of[s] = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 36;
    recv_idle_pct = 80;
    test_empty_list();
    test_head_tail_middle_edits();
    test_clear();
    test_random_edits(100);

    send_idle_pct = 80;
    recv_idle_pct = 36;
    test_full_list();
    test_random_edits(95);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_edits(95);

    @(negedge clk);
    in_valid <= 1'b0;
    while (list_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CLKS) @(posedge clk);

    $display("Ran %0d commands (%0d traversals, %0d rejected) under three idle mixes.",
             commands_sent, traversals, rejects);
    $display("Checked %0d result beats with %0d mismatches.", beats_checked, fault_count);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/slle_pkg.sv
rtl/core/slle_ram.sv
rtl/core/slle_ctrl.sv
rtl/core/slle_dp.sv
rtl/core/static_linked_list_engine_unit.sv
tb/tb_static_linked_list_engine_unit.sv
